// ----- sv/dvrt_pkg.sv -----
`timescale 1ns / 1ps

package dvrt_pkg;

    // Field widths of one request and one result.
    localparam int REQ_W      = 2;
    localparam int NODE_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 3 * NODE_W;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 40;

    // Bit positions inside the request beat.
    localparam int S_REQ_LSB  = 0;
    localparam int S_DEST_LSB = S_REQ_LSB + REQ_W;
    localparam int S_SRC_LSB  = S_DEST_LSB + NODE_W;
    localparam int S_HOP_LSB  = S_SRC_LSB + NODE_W;

    // Bit positions inside the result beat.
    localparam int M_STATUS_LSB = 0;
    localparam int M_FOUND_BIT  = M_STATUS_LSB + STATUS_W;
    localparam int M_HOP_LSB    = M_FOUND_BIT + 1;
    localparam int M_METRIC_LSB = M_HOP_LSB + NODE_W;

    // Request codes.
    localparam logic [REQ_W-1:0] RQ_ADVERTISE = 2'd0;
    localparam logic [REQ_W-1:0] RQ_WITHDRAW  = 2'd1;
    localparam logic [REQ_W-1:0] RQ_LOOKUP    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IMPROVED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KEPT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;
        logic accept;
        logic scan_rd;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic in_trivial;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/dvrt_ctrl.sv -----
`timescale 1ns / 1ps

module dvrt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  dvrt_pkg::sts_t sts,
    output dvrt_pkg::cmd_t cmd
);
    import dvrt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    // Reserved destinations and unused codes skip the scan.
                    state_next = sts.in_trivial ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last slot read is compared in this cycle.
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- sv/dvrt_dpath.sv -----
`timescale 1ns / 1ps

module dvrt_dpath #(
    parameter int ENTRIES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dvrt_pkg::cmd_t                 cmd,
    output dvrt_pkg::sts_t                 sts,
    input  logic [dvrt_pkg::S_DATA_W-1:0]  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dvrt_pkg::M_DATA_W-1:0]  m_data
);
    import dvrt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Route store: {dest, via, metric} per slot.
    logic [ENTRY_W-1:0] mem [ENTRIES];
    logic [ENTRY_W-1:0] q_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_en_reg;

    logic [REQ_W-1:0]  req_reg;
    logic [NODE_W-1:0] dst_reg;
    logic [NODE_W-1:0] src_reg;
    logic [NODE_W-1:0] hop_reg;

    logic              have_hit_reg;
    logic              have_free_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [NODE_W-1:0] hit_via_reg;
    logic [NODE_W-1:0] hit_metric_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [NODE_W-1:0] in_dst;
    logic [REQ_W-1:0]  in_req;
    logic [NODE_W-1:0] q_dst;
    logic              is_hit;
    logic              is_free;
    logic              trivial;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                dec_we;
    logic [IDX_W-1:0]    dec_addr;
    logic [ENTRY_W-1:0]  dec_wdata;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
    logic [NODE_W-1:0]   res_hop;
    logic [NODE_W-1:0]   res_metric;

    assign in_req  = s_data[S_REQ_LSB +: REQ_W];
    assign in_dst  = s_data[S_DEST_LSB +: NODE_W];
    assign q_dst   = q_reg[ENTRY_W-1 -: NODE_W];
    assign is_hit  = cmp_en_reg && (q_dst == dst_reg);
    assign is_free = cmp_en_reg && (q_dst == '0);
    assign trivial = (dst_reg == '0) || (req_reg > RQ_LOOKUP);

    assign sts.cnt_last   = (cnt_reg == LAST_IDX);
    assign sts.in_trivial = (in_dst == '0) || (in_req > RQ_LOOKUP);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Slot counter, shared by the clearing pass and the scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan_rd;
            if (cmd.accept) begin
                cnt_reg <= '0;
            end else if (cmd.clr_en || cmd.scan_rd) begin
                cnt_reg <= sts.cnt_last ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // Request capture and scan trackers.
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cnt_reg;
        if (cmd.accept) begin
            req_reg       <= in_req;
            dst_reg       <= in_dst;
            src_reg       <= s_data[S_SRC_LSB +: NODE_W];
            hop_reg       <= s_data[S_HOP_LSB +: NODE_W];
            have_hit_reg  <= 1'b0;
            have_free_reg <= 1'b0;
        end else begin
            if (is_hit && !have_hit_reg) begin
                have_hit_reg   <= 1'b1;
                hit_idx_reg    <= cmp_idx_reg;
                hit_via_reg    <= q_reg[NODE_W +: NODE_W];
                hit_metric_reg <= q_reg[0 +: NODE_W];
            end
            if (is_free && !have_free_reg) begin
                have_free_reg <= 1'b1;
                free_idx_reg  <= cmp_idx_reg;
            end
        end
    end

    // Outcome of the request once the scan is complete or skipped.
    always_comb begin
        dec_we     = 1'b0;
        dec_addr   = hit_idx_reg;
        dec_wdata  = {dst_reg, src_reg, hop_reg};
        res_status = ST_NOTFOUND;
        res_found  = 1'b0;
        res_hop    = '0;
        res_metric = '0;
        if (!trivial) begin
            if (req_reg == RQ_ADVERTISE) begin
                if (!have_hit_reg) begin
                    if (have_free_reg) begin
                        dec_we     = 1'b1;
                        dec_addr   = free_idx_reg;
                        res_status = ST_ADDED;
                        res_hop    = src_reg;
                        res_metric = hop_reg;
                    end else begin
                        res_status = ST_FULL;
                    end
                end else if (hop_reg < hit_metric_reg) begin
                    dec_we     = 1'b1;
                    res_status = ST_IMPROVED;
                    res_found  = 1'b1;
                    res_hop    = src_reg;
                    res_metric = hop_reg;
                end else begin
                    res_status = ST_KEPT;
                    res_found  = 1'b1;
                    res_hop    = hit_via_reg;
                    res_metric = hit_metric_reg;
                end
            end else if (have_hit_reg) begin
                res_status = ST_FOUND;
                res_found  = 1'b1;
                if (req_reg == RQ_WITHDRAW) begin
                    dec_we    = 1'b1;
                    dec_wdata = '0;
                end else begin
                    res_hop    = hit_via_reg;
                    res_metric = hit_metric_reg;
                end
            end
        end
    end

    // Write port: the clearing pass or the commit of one request.
    assign mem_we    = cmd.clr_en || (cmd.commit && dec_we);
    assign mem_waddr = cmd.clr_en ? cnt_reg : dec_addr;
    assign mem_wdata = cmd.clr_en ? '0 : dec_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        q_reg <= mem[cnt_reg];
    end

    // Result register; it holds a beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= M_DATA_W'({res_metric, res_hop, res_found, res_status});
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/distance_vector_route_table_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  request: type, dest, source, hop count
// m_axis    out        m_axis_tvalid/m_axis_tready  result: status, found, next hop, metric
//
// Each request runs a scan that reads one route slot per cycle from the store;
// a new request is accepted only after the result of the last one is committed.
// A request for destination 0 or with an unused type skips the scan.
// After reset a clearing pass empties the store; s_axis_tready stays low.
// A result beat waits in the output register while m_axis_tready is low; the next
// request is accepted meanwhile, and its result is held back until the register frees.

module distance_vector_route_table_core #(
    parameter int ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // req_type[1:0], dest_node[17:2], source_node[33:18], hop_count[49:34], zeros above
    input  logic [dvrt_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[2:0], found[3], next_hop[19:4], route_metric[35:20], zeros above
    output logic [dvrt_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import dvrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer for clearing, scanning and committing.
    dvrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Route store, scan trackers and result register.
    dvrt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_axis_tdata),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule

// ----- sv/dvrt_checker.sv -----
`timescale 1ns / 1ps

module dvrt_assertions (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dvrt_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import dvrt_pkg::*;

    logic [STATUS_W-1:0] st;
    logic                fnd;
    logic [NODE_W-1:0]   hop;
    logic [NODE_W-1:0]   met;

    assign st  = m_axis_tdata[M_STATUS_LSB +: STATUS_W];
    assign fnd = m_axis_tdata[M_FOUND_BIT];
    assign hop = m_axis_tdata[M_HOP_LSB +: NODE_W];
    assign met = m_axis_tdata[M_METRIC_LSB +: NODE_W];

    // A stalled result beat stays offered.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // The store is being cleared right after reset, so no request is taken.
    a_clear_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("request accepted during the clearing pass");

    // The found flag agrees with the status code.
    a_found_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (fnd == ((st == ST_IMPROVED) || (st == ST_KEPT) ||
                                   (st == ST_FOUND))))
        else $error("found flag disagrees with status");

    // Refused requests report an empty route.
    a_empty_route: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && ((st == ST_NOTFOUND) || (st == ST_FULL)) |->
            (hop == '0) && (met == '0))
        else $error("refused request reports a route");

endmodule

bind distance_vector_route_table_core dvrt_assertions u_dvrt_assertions (.*);
